@@ rtl/atf_pkg.sv @@
// Package with constants, types and the identify table for the task-file controller.
package atf_pkg;

    localparam int CARD_SECTORS = 64;
    localparam int BLK = 512;
    localparam int PTR_W = 9;
    localparam int SEC_W = (CARD_SECTORS > 1) ? $clog2(CARD_SECTORS) : 1;
    localparam int STORE_AW = SEC_W + PTR_W;
    localparam int LBA_W = 28;
    localparam int IDENT_LEN = 124;

    localparam logic [7:0] ST_ERR = 8'h01;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_RDY = 8'h40;
    localparam logic [7:0] ER_NOMEDIA = 8'h01;
    localparam logic [7:0] ER_ABORT = 8'h04;
    localparam logic [7:0] ER_IDNF = 8'h10;
    localparam logic [7:0] ER_UNC = 8'h40;

    localparam logic [7:0] CMD_READ = 8'h20;
    localparam logic [7:0] CMD_READ_NR = 8'h21;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CMD_WRITE_NR = 8'h31;
    localparam logic [7:0] CMD_ERASE = 8'hC0;
    localparam logic [7:0] CMD_IDENT = 8'hEC;
    localparam logic [7:0] CMD_SETF = 8'hEF;

    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_ERR = 3'd1;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_LBA0 = 3'd3;
    localparam logic [2:0] REG_LBA1 = 3'd4;
    localparam logic [2:0] REG_LBA2 = 3'd5;
    localparam logic [2:0] REG_LBA3 = 3'd6;
    localparam logic [2:0] REG_CMD = 3'd7;

    typedef enum logic [1:0] {
        FILL_ZERO = 2'd0,
        FILL_IDENT = 2'd1,
        FILL_LOAD = 2'd2
    } t_fill;

    typedef enum logic [1:0] {
        SWEEP_NONE = 2'd0,
        SWEEP_BUF = 2'd1,
        SWEEP_ERASE = 2'd2,
        SWEEP_SAVE = 2'd3
    } t_sweep_kind;

    typedef struct packed {
        logic              start;
        t_sweep_kind       kind;
        t_fill             fill;
        logic [SEC_W-1:0]  sector;
        logic              buf_we;
        logic [PTR_W-1:0]  buf_addr;
        logic [7:0]        buf_wdata;
        logic              buf_re;
    } t_dp_cmd;

    typedef struct packed {
        logic       busy;
        logic [7:0] buf_rdata;
    } t_dp_status;

    function automatic logic [7:0] ident_byte(input logic [PTR_W-1:0] a);
        logic [7:0] v;
        case (a)
            9'd0: v = 8'h84;   9'd1: v = 8'h8A;   9'd3: v = 8'h08;
            9'd6: v = 8'h08;   9'd9: v = 8'h40;   9'd11: v = 8'h02;
            9'd12: v = 8'h20;  9'd14: v = 8'h08;
            9'd20: v = "A"; 9'd21: v = "C"; 9'd22: v = "W"; 9'd23: v = "D";
            9'd24: v = "6"; 9'd25: v = "5"; 9'd26: v = "0"; 9'd27: v = "2";
            9'd28: v = "E"; 9'd29: v = "M"; 9'd30: v = "U"; 9'd31: v = "C";
            9'd32: v = "F"; 9'd33: v = "1"; 9'd34: v = "0"; 9'd35: v = "1";
            9'd36: v = "0"; 9'd37: v = "1"; 9'd38: v = "0"; 9'd39: v = "1";
            9'd40: v = 8'h01;  9'd42: v = 8'h04;  9'd44: v = 8'h04;
            9'd46: v = "1"; 9'd47: v = "."; 9'd48: v = "0";
            9'd54: v = "A"; 9'd55: v = "C"; 9'd56: v = "W"; 9'd57: v = "D";
            9'd58: v = "6"; 9'd59: v = "5"; 9'd60: v = "0"; 9'd61: v = "2";
            9'd62: v = "E"; 9'd63: v = "M"; 9'd64: v = "U"; 9'd65: v = "C";
            9'd66: v = "F";
            9'd94: v = 8'h01;  9'd99: v = 8'h02;  9'd103: v = 8'h02;
            9'd106: v = 8'h01; 9'd109: v = 8'h08; 9'd110: v = 8'h08;
            9'd112: v = 8'h20; 9'd116: v = 8'h08; 9'd118: v = 8'h01;
            9'd119: v = 8'h01; 9'd122: v = 8'h08;
            default: v = 8'h00;
        endcase
        if (a >= 9'd49 && a <= 9'd53) v = " ";
        if (a >= 9'd67 && a <= 9'd93) v = " ";
        return v;
    endfunction

endpackage

@@ rtl/atf_if.sv @@
// Valid/ready channel interfaces for bus accesses and their results.
interface atf_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    modport source (output valid, output mode, output reg_addr, output write_data, input ready);
    modport sink (input valid, input mode, input reg_addr, input write_data, output ready);
endinterface

interface atf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

@@ rtl/ata_task_file_sector_controller.sv @@
// Top level of the task-file sector controller.
//   channel  direction  payload
//   in_ch    sink       mode, reg_addr, write_data
//   out_ch   source     read_data
//   cfg      write      media_present
// A register access returns its result from the output state; a data-port read in a
// transfer first passes a buffer-read state, and a command or the last byte written
// to a sector a wait state. Commands and the last byte of a sector may start a sector
// sweep; the next access waits until it ends.
// After reset a clearing pass blanks the store and buffer.
// A stalled result holds the block until it is taken.
module ata_task_file_sector_controller (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data,
    atf_in_if.sink    in_ch,
    atf_out_if.source out_ch
);
    import atf_pkg::*;

    logic       r_media;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_media <= 1'b1;
        end else if (i_cfg_we) begin
            r_media <= i_cfg_data;
        end
    end

    atf_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_media(r_media),
        .in_ch(in_ch), .out_ch(out_ch), .o_cmd(w_cmd), .i_status(w_status)
    );

    atf_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status)
    );

endmodule

@@ rtl/atf_datapath.sv @@
// Sector buffer, card store and the sweep engine that moves whole sectors.
module atf_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  atf_pkg::t_dp_cmd    i_cmd,
    output atf_pkg::t_dp_status o_status
);
    import atf_pkg::*;

    logic [7:0] r_buf [BLK];
    logic [7:0] r_store [CARD_SECTORS*BLK];

    logic              r_active, n_active;
    logic              r_clearing, n_clearing;
    logic [STORE_AW:0] r_clr, n_clr;
    t_sweep_kind       r_kind, n_kind;
    t_fill             r_fill, n_fill;
    logic [SEC_W-1:0]  r_sec, n_sec;
    logic [PTR_W:0]    r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [PTR_W-1:0]  r_pidx;
    logic [7:0]        r_sdata;
    logic [7:0]        r_rdata;
    logic [7:0]        r_bdata;

    logic [PTR_W-1:0] w_i;
    assign w_i = r_idx[PTR_W-1:0];

    always_comb begin
        n_active = r_active;
        n_kind = r_kind;
        n_fill = r_fill;
        n_sec = r_sec;
        n_idx = r_idx;
        n_pend = 1'b0;
        n_clearing = r_clearing;
        n_clr = r_clr;
        if (r_clearing) begin
            n_clr = r_clr + 1'b1;
            if (r_clr == (STORE_AW+1)'(CARD_SECTORS*BLK - 1)) n_clearing = 1'b0;
        end else if (i_cmd.start) begin
            n_active = 1'b1;
            n_kind = i_cmd.kind;
            n_fill = i_cmd.fill;
            n_sec = i_cmd.sector;
            n_idx = '0;
        end else if (r_active) begin
            n_pend = (r_kind == SWEEP_BUF && r_fill == FILL_LOAD) || r_kind == SWEEP_SAVE;
            if (r_idx == (PTR_W+1)'(BLK - 1)) n_active = 1'b0;
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_kind <= SWEEP_NONE;
            r_fill <= FILL_ZERO;
            r_sec <= '0;
            r_idx <= '0;
            r_pend <= 1'b0;
            r_clearing <= 1'b1;
            r_clr <= '0;
        end else begin
            r_active <= n_active;
            r_kind <= n_kind;
            r_fill <= n_fill;
            r_sec <= n_sec;
            r_idx <= n_idx;
            r_pend <= n_pend;
            r_clearing <= n_clearing;
            r_clr <= n_clr;
        end
    end

    // Store port: clearing, erase writes, save writes from the buffer; load reads.
    always_ff @(posedge i_clk) begin
        r_pidx <= w_i;
        if (r_clearing) begin
            r_store[r_clr[STORE_AW-1:0]] <= 8'h00;
        end else if (r_active && r_kind == SWEEP_ERASE) begin
            r_store[{r_sec, w_i}] <= 8'h00;
        end else if (r_pend && r_kind == SWEEP_SAVE) begin
            r_store[{r_sec, r_pidx}] <= r_bdata;
        end
        r_sdata <= r_store[{r_sec, w_i}];
    end

    // Buffer port: clearing, host accesses, fills and loads; save reads.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_buf[r_clr[PTR_W-1:0]] <= 8'h00;
        end else if (r_active && r_kind == SWEEP_BUF && r_fill == FILL_ZERO) begin
            r_buf[w_i] <= 8'h00;
        end else if (r_active && r_kind == SWEEP_BUF && r_fill == FILL_IDENT) begin
            r_buf[w_i] <= ident_byte(w_i);
        end else if (r_pend && r_kind == SWEEP_BUF) begin
            r_buf[r_pidx] <= r_sdata;
        end else if (i_cmd.buf_we) begin
            r_buf[i_cmd.buf_addr] <= i_cmd.buf_wdata;
        end
        if (i_cmd.buf_re) r_rdata <= r_buf[i_cmd.buf_addr];
        r_bdata <= r_buf[w_i];
    end

    assign o_status.busy = r_active || r_pend || r_clearing;
    assign o_status.buf_rdata = r_rdata;

endmodule

@@ rtl/atf_controller.sv @@
// Task-file registers and the command state machine.
module atf_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_media,
    atf_in_if.sink              in_ch,
    atf_out_if.source           out_ch,
    output atf_pkg::t_dp_cmd    o_cmd,
    input  atf_pkg::t_dp_status i_status
);
    import atf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WAIT = 4'b0010,
        S_RDATA = 4'b0100,
        S_OUT = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic [8:0]       r_done, n_done;
    logic [7:0]       r_err, n_err, r_cnt, n_cnt;
    logic [7:0]       r_l0, n_l0, r_l1, n_l1, r_l2, n_l2;
    logic [3:0]       r_l3, n_l3;
    logic             r_erb, n_erb, r_drq, n_drq;
    logic             r_ident, n_ident, r_xfer, n_xfer;
    logic [7:0]       r_out, n_out;
    logic             r_fromb, n_fromb;

    logic [LBA_W-1:0] w_lba;
    logic [LBA_W:0]   w_cur;
    logic             w_inr, w_acc, w_curok;
    logic [7:0]       w_status;

    assign w_lba = {r_l3, r_l2, r_l1, r_l0};
    assign w_cur = {1'b0, w_lba} + (LBA_W+1)'(r_done);
    assign w_inr = w_lba < LBA_W'(CARD_SECTORS);
    assign w_curok = w_cur < (LBA_W+1)'(CARD_SECTORS);
    assign w_acc = in_ch.valid && in_ch.ready;
    assign w_status = ST_RDY | (r_drq ? ST_DRQ : 8'h00) | (r_erb ? ST_ERR : 8'h00);
    assign in_ch.ready = (r_state == S_IDLE) && !i_status.busy;
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.read_data = r_out;

    always_comb begin
        n_state = r_state;
        n_ptr = r_ptr; n_done = r_done; n_err = r_err; n_cnt = r_cnt;
        n_l0 = r_l0; n_l1 = r_l1; n_l2 = r_l2; n_l3 = r_l3;
        n_erb = r_erb; n_drq = r_drq; n_ident = r_ident; n_xfer = r_xfer;
        n_out = r_out; n_fromb = 1'b0;
        o_cmd = '0;
        o_cmd.buf_addr = r_ptr;
        o_cmd.buf_wdata = in_ch.write_data;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_out = 8'h00;
                    n_state = S_OUT;
                    if (in_ch.mode) begin
                        case (in_ch.reg_addr)
                            REG_DATA: begin
                                if (r_xfer) begin
                                    o_cmd.buf_we = 1'b1;
                                    if (r_ptr != PTR_W'(BLK - 1)) begin
                                        n_ptr = r_ptr + 1'b1;
                                    end else begin
                                        n_ptr = '0;
                                        if (!i_media || !w_curok) begin
                                            n_erb = 1'b1; n_err = r_err | ER_UNC;
                                        end else begin
                                            o_cmd.start = 1'b1;
                                            o_cmd.kind = SWEEP_SAVE;
                                            o_cmd.sector = w_cur[SEC_W-1:0];
                                        end
                                        n_done = r_done + 1'b1;
                                        if (r_done + 9'd1 >= {1'b0, r_cnt}) begin
                                            n_xfer = 1'b0; n_drq = 1'b0;
                                        end
                                        n_state = S_WAIT;
                                    end
                                end
                            end
                            REG_ERR: ;
                            REG_COUNT: n_cnt = in_ch.write_data;
                            REG_LBA0: n_l0 = in_ch.write_data;
                            REG_LBA1: n_l1 = in_ch.write_data;
                            REG_LBA2: n_l2 = in_ch.write_data;
                            REG_LBA3: n_l3 = in_ch.write_data[3:0];
                            default: begin
                                n_erb = 1'b0; n_drq = 1'b0; n_err = 8'h00;
                                n_ptr = '0; n_done = '0;
                                o_cmd.sector = w_lba[SEC_W-1:0];
                                n_state = S_WAIT;
                                if (!i_media) begin
                                    n_erb = 1'b1; n_err = ER_NOMEDIA;
                                end else if (r_xfer || r_ident) begin
                                    n_erb = 1'b1; n_err = ER_ABORT;
                                end else begin
                                    case (in_ch.write_data)
                                        CMD_ERASE: begin
                                            if (!w_inr) begin
                                                n_erb = 1'b1; n_err = ER_ABORT | ER_IDNF;
                                            end else begin
                                                o_cmd.start = 1'b1;
                                                o_cmd.kind = SWEEP_ERASE;
                                            end
                                        end
                                        CMD_IDENT: begin
                                            o_cmd.start = 1'b1;
                                            o_cmd.kind = SWEEP_BUF;
                                            o_cmd.fill = FILL_IDENT;
                                            n_drq = 1'b1; n_ident = 1'b1;
                                        end
                                        CMD_READ, CMD_READ_NR: begin
                                            if (!w_inr) begin
                                                n_erb = 1'b1; n_err = ER_ABORT | ER_IDNF;
                                            end else begin
                                                o_cmd.start = 1'b1;
                                                o_cmd.kind = SWEEP_BUF;
                                                o_cmd.fill = FILL_LOAD;
                                                n_drq = 1'b1; n_xfer = 1'b1;
                                            end
                                        end
                                        CMD_WRITE, CMD_WRITE_NR: begin
                                            if (!w_inr) begin
                                                n_erb = 1'b1; n_err = ER_ABORT | ER_IDNF;
                                            end else begin
                                                n_drq = 1'b1; n_xfer = 1'b1;
                                            end
                                        end
                                        CMD_SETF: ;
                                        default: begin
                                            n_erb = 1'b1; n_err = ER_ABORT;
                                        end
                                    endcase
                                end
                            end
                        endcase
                    end else begin
                        case (in_ch.reg_addr)
                            REG_DATA: begin
                                if (r_ident || r_xfer) begin
                                    o_cmd.buf_re = 1'b1;
                                    n_state = S_RDATA;
                                    if (r_ptr != PTR_W'(BLK - 1)) begin
                                        n_ptr = r_ptr + 1'b1;
                                    end else if (r_ident) begin
                                        n_ptr = '0; n_ident = 1'b0; n_drq = 1'b0;
                                    end else begin
                                        n_ptr = '0;
                                        n_done = r_done + 1'b1;
                                        if (r_done + 9'd1 < {1'b0, r_cnt}) begin
                                            if (!i_media) begin
                                                n_erb = 1'b1; n_err = r_err | ER_UNC;
                                                n_xfer = 1'b0; n_drq = 1'b0;
                                            end else begin
                                                n_fromb = 1'b1;
                                            end
                                        end else begin
                                            n_xfer = 1'b0; n_drq = 1'b0;
                                        end
                                    end
                                end
                            end
                            REG_ERR: n_out = r_err;
                            REG_COUNT: n_out = r_cnt;
                            REG_LBA0: n_out = r_l0;
                            REG_LBA1: n_out = r_l1;
                            REG_LBA2: n_out = r_l2;
                            REG_LBA3: n_out = {4'hE, r_l3};
                            default: n_out = i_media ? w_status : 8'h00;
                        endcase
                    end
                end
            end
            S_RDATA: begin
                n_out = i_status.buf_rdata;
                n_state = S_OUT;
                if (r_fromb) begin
                    // Next sector of a multi-sector read: load, or blank past the end.
                    o_cmd.start = 1'b1;
                    o_cmd.kind = SWEEP_BUF;
                    o_cmd.fill = w_curok ? FILL_LOAD : FILL_ZERO;
                    o_cmd.sector = w_cur[SEC_W-1:0];
                end
            end
            S_WAIT: n_state = S_OUT;
            S_OUT: if (out_ch.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ptr <= '0; r_done <= '0; r_err <= '0; r_cnt <= '0;
            r_l0 <= '0; r_l1 <= '0; r_l2 <= '0; r_l3 <= '0;
            r_erb <= 1'b0; r_drq <= 1'b0; r_ident <= 1'b0; r_xfer <= 1'b0;
            r_fromb <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr <= n_ptr; r_done <= n_done; r_err <= n_err; r_cnt <= n_cnt;
            r_l0 <= n_l0; r_l1 <= n_l1; r_l2 <= n_l2; r_l3 <= n_l3;
            r_erb <= n_erb; r_drq <= n_drq; r_ident <= n_ident; r_xfer <= n_xfer;
            r_fromb <= n_fromb;
        end
        r_out <= n_out;
    end

endmodule

@@ rtl/atf_checker.sv @@
// Port-level checker for the task-file controller, bound to the top level.
module atf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("two accesses taken back to back");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("result after reset");
endmodule

bind ata_task_file_sector_controller atf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.read_data)
);
